/* rtl/efwm_pkg.sv */
// Shared types and constants for the event flag waiter matcher.
package efwm_pkg;

    localparam int WAITER_SLOTS = 16;
    localparam int FLAG_W       = 32;
    localparam int ID_W         = 32;

    localparam logic [1:0] KIND_UPDATE = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_ZERO_MASK = 2'd2;

    // One waiter slot as seen by its neighbor.
    typedef struct packed {
        logic              valid;
        logic [FLAG_W-1:0] mask;
        logic [ID_W-1:0]   id;
    } t_entry;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic              add_en;
        logic              shift_en;
        logic [FLAG_W-1:0] flags;
        logic [FLAG_W-1:0] wait_mask;
        logic [ID_W-1:0]   new_id;
        logic [ID_W-1:0]   rid;
    } t_cmd;

endpackage

/* rtl/efwm_cell.sv */
// One waiter slot of the row: holds mask and id, matches and shifts toward the head.
module efwm_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  efwm_pkg::t_cmd  i_cmd,
    input  logic            i_prev_valid,
    input  efwm_pkg::t_entry i_next,
    input  logic            i_hit_before,
    input  logic            i_rm_before,
    output efwm_pkg::t_entry o_entry,
    output logic            o_first_hit,
    output logic            o_hit_before,
    output logic            o_rm_before
);

    logic                        r_valid;
    logic [efwm_pkg::FLAG_W-1:0] r_mask;
    logic [efwm_pkg::ID_W-1:0]   r_id;
    logic                        w_hit;
    logic                        w_rm;
    logic                        w_shift;
    logic                        w_load;

    assign w_hit = r_valid && ((i_cmd.flags & r_mask) == r_mask);
    assign w_rm  = r_valid && (r_id == i_cmd.rid);

    // at or behind the first matching id: take the neighbor's contents
    assign w_shift = i_cmd.shift_en && (i_rm_before || w_rm);
    // first free slot takes a new waiter
    assign w_load  = i_cmd.add_en && !r_valid && i_prev_valid;

    assign o_first_hit  = w_hit && !i_hit_before;
    assign o_hit_before = i_hit_before || w_hit;
    assign o_rm_before  = i_rm_before || w_rm;

    assign o_entry.valid = r_valid;
    assign o_entry.mask  = r_mask;
    assign o_entry.id    = r_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_shift) begin
            r_valid <= i_next.valid;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_mask <= i_next.mask;
            r_id   <= i_next.id;
        end else if (w_load) begin
            r_mask <= i_cmd.wait_mask;
            r_id   <= i_cmd.new_id;
        end
    end

endmodule

/* rtl/event_flag_waiter_matcher.sv */
// Top level: flag word, control sequencer, waiter cell row and result register.
//
// Event flag group with wait-all-and-clear waiters. The block holds a 32-bit
// flag word and a row of WAITER_SLOTS cells, each one waiter (mask, id) kept
// in insertion order with the valid ones packed at the head of the row. Every
// input word gives one or more result words; the final one carries o_last.
// Add (kind 1) appends a waiter and returns a fresh id, or reports a zero mask
// or a full table. Remove (kind 2) deletes every waiter with that id and the
// cells behind it close up. Update (kind 0) sets then clears flag bits; if the
// word changed, the first waiter whose mask is fully set fires, its bits are
// cleared, and this repeats until none matches, then a summary word follows.
// Timing: add, unused kinds and an update that leaves the flag word unchanged
// give a single result word and can be accepted back to back. An update that
// changes the word applies it, then gives one word per firing and then the
// summary; the priority match across the cell row fires one waiter per cycle
// while the result register is free. A remove shifts the row once per
// matching waiter, then gives its result word. A new input word is taken
// only when the sequencer is idle and the result register is free or being
// emptied in that cycle; output stalls hold the sequencer.
module event_flag_waiter_matcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_set_mask,
    input  logic [31:0] i_clear_mask,
    input  logic [31:0] i_wait_mask,
    input  logic [31:0] i_remove_id,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_fired,
    output logic [31:0] o_waiter_id,
    output logic [31:0] o_flag_word,
    output logic        o_last
);

    localparam int SLOTS = efwm_pkg::WAITER_SLOTS;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_FIRE   = 2'd1;
    localparam logic [1:0] ST_REMOVE = 2'd2;

    // sequencer and flag state
    logic [1:0]                  r_state, n_state;
    logic [efwm_pkg::FLAG_W-1:0] r_flags, n_flags;
    logic [efwm_pkg::ID_W-1:0]   r_next_id, n_next_id;
    logic [efwm_pkg::ID_W-1:0]   r_rid, n_rid;

    // result register
    logic                        r_out_valid, n_out_valid;
    logic [1:0]                  r_status, n_status;
    logic                        r_fired, n_fired;
    logic [efwm_pkg::ID_W-1:0]   r_id, n_id;
    logic [efwm_pkg::FLAG_W-1:0] r_flag_word, n_flag_word;
    logic                        r_last, n_last;

    // cell row
    efwm_pkg::t_cmd              w_cmd;
    efwm_pkg::t_entry            w_entry [SLOTS];
    efwm_pkg::t_entry            w_next  [SLOTS];
    logic [SLOTS:0]              w_hit_chain;
    logic [SLOTS:0]              w_rm_chain;
    logic [SLOTS-1:0]            w_first_hit;
    logic [SLOTS-1:0]            w_valid;
    logic [efwm_pkg::FLAG_W-1:0] w_sel_mask;
    logic [efwm_pkg::ID_W-1:0]   w_sel_id;

    logic                        w_out_free;
    logic                        w_accept;
    logic [efwm_pkg::FLAG_W-1:0] w_upd_flags;
    logic                        w_full;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && w_out_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_upd_flags = (r_flags | i_set_mask) & ~i_clear_mask;
    assign w_full      = w_valid[SLOTS-1];

    assign w_hit_chain[0] = 1'b0;
    assign w_rm_chain[0]  = 1'b0;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            // each cell hands its contents to the one in front during a shift
            if (g == SLOTS - 1) begin : g_tail
                assign w_next[g] = '0;
            end else begin : g_body
                assign w_next[g] = w_entry[g+1];
            end

            efwm_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (w_cmd),
                .i_prev_valid ((g == 0) ? 1'b1 : w_valid[(g == 0) ? 0 : g-1]),
                .i_next       (w_next[g]),
                .i_hit_before (w_hit_chain[g]),
                .i_rm_before  (w_rm_chain[g]),
                .o_entry      (w_entry[g]),
                .o_first_hit  (w_first_hit[g]),
                .o_hit_before (w_hit_chain[g+1]),
                .o_rm_before  (w_rm_chain[g+1])
            );

            assign w_valid[g] = w_entry[g].valid;
        end
    endgenerate

    // the first matching cell is one-hot, so an OR picks its mask and id
    always_comb begin
        w_sel_mask = '0;
        w_sel_id   = '0;
        for (int i = 0; i < SLOTS; i++) begin
            w_sel_mask = w_sel_mask | (w_entry[i].mask & {efwm_pkg::FLAG_W{w_first_hit[i]}});
            w_sel_id   = w_sel_id | (w_entry[i].id & {efwm_pkg::ID_W{w_first_hit[i]}});
        end
    end

    always_comb begin
        n_state     = r_state;
        n_flags     = r_flags;
        n_next_id   = r_next_id;
        n_rid       = r_rid;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_fired     = r_fired;
        n_id        = r_id;
        n_flag_word = r_flag_word;
        n_last      = r_last;

        w_cmd.add_en    = 1'b0;
        w_cmd.shift_en  = 1'b0;
        w_cmd.flags     = r_flags;
        w_cmd.wait_mask = i_wait_mask;
        w_cmd.new_id    = r_next_id + 1'b1;
        w_cmd.rid       = r_rid;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    // default result word: summary with the current flags
                    n_out_valid = 1'b1;
                    n_status    = efwm_pkg::STATUS_OK;
                    n_fired     = 1'b0;
                    n_id        = '0;
                    n_flag_word = r_flags;
                    n_last      = 1'b1;
                    case (i_kind)
                        efwm_pkg::KIND_UPDATE: begin
                            n_flags     = w_upd_flags;
                            n_flag_word = w_upd_flags;
                            if (w_upd_flags != r_flags) begin
                                n_out_valid = 1'b0;
                                n_state     = ST_FIRE;
                            end
                        end
                        efwm_pkg::KIND_ADD: begin
                            if (i_wait_mask == '0) begin
                                n_status = efwm_pkg::STATUS_ZERO_MASK;
                            end else if (w_full) begin
                                n_status = efwm_pkg::STATUS_FULL;
                            end else begin
                                w_cmd.add_en = 1'b1;
                                n_next_id    = r_next_id + 1'b1;
                                n_id         = r_next_id + 1'b1;
                            end
                        end
                        efwm_pkg::KIND_REMOVE: begin
                            n_out_valid = 1'b0;
                            n_rid       = i_remove_id;
                            n_state     = ST_REMOVE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FIRE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = efwm_pkg::STATUS_OK;
                    if (w_hit_chain[SLOTS]) begin
                        n_flags     = r_flags & ~w_sel_mask;
                        n_fired     = 1'b1;
                        n_id        = w_sel_id;
                        n_flag_word = r_flags & ~w_sel_mask;
                        n_last      = 1'b0;
                    end else begin
                        n_fired     = 1'b0;
                        n_id        = '0;
                        n_flag_word = r_flags;
                        n_last      = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end
            end
            ST_REMOVE: begin
                if (w_rm_chain[SLOTS]) begin
                    // drop the first matching waiter, row closes up
                    w_cmd.shift_en = 1'b1;
                end else if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = efwm_pkg::STATUS_OK;
                    n_fired     = 1'b0;
                    n_id        = r_rid;
                    n_flag_word = r_flags;
                    n_last      = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_flags     <= '0;
            r_next_id   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_flags     <= n_flags;
            r_next_id   <= n_next_id;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rid       <= n_rid;
        r_status    <= n_status;
        r_fired     <= n_fired;
        r_id        <= n_id;
        r_flag_word <= n_flag_word;
        r_last      <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_fired     = r_fired;
    assign o_waiter_id = r_id;
    assign o_flag_word = r_flag_word;
    assign o_last      = r_last;

    // valid waiters always occupy a prefix of the row
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + 1'b1)) == '0)
        else $error("waiter row not compacted");

    // priority match selects at most one cell
    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first_hit))
        else $error("more than one first hit");

    // a firing must clear at least one bit, or the update would never end
    a_fire_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIRE) && w_hit_chain[SLOTS] |-> (w_sel_mask != '0))
        else $error("firing waiter with empty mask");

    // a fired word is never the closing word of its input
    a_fired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fired |-> !o_last && (o_status == efwm_pkg::STATUS_OK))
        else $error("fired result marked last");

    // an accepted remove always enters the shift state
    a_remove_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_kind == efwm_pkg::KIND_REMOVE) |=> (r_state == ST_REMOVE))
        else $error("remove not started");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the event flag waiter matcher: directed and random words.
`timescale 1ns / 1ps

module testbench;

    // Kind 3 has no meaning in the block; it must still answer with one word.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam int STALL_LIMIT    = 2000;  // cycles with no word moving on either side
    localparam int DRAIN_TAIL     = 40;    // settle time once every result word is in
    localparam int LONG_HOLD      = 300;   // receiver hold-off in the backpressure test
    localparam int MAX_REPORTS    = 100;

    typedef struct packed {
        logic [1:0]  status;
        logic        fired;
        logic [31:0] waiter_id;
        logic [31:0] flag_word;
        logic        last;
    } t_result_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_kind;
    logic [31:0] i_set_mask;
    logic [31:0] i_clear_mask;
    logic [31:0] i_wait_mask;
    logic [31:0] i_remove_id;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;
    logic        o_fired;
    logic [31:0] o_waiter_id;
    logic [31:0] o_flag_word;
    logic        o_last;

    // Shadow of the flag group: flag word, last id handed out, waiters in order.
    logic [31:0]  group_flags;
    logic [31:0]  last_issued_id;
    logic [31:0]  waiter_mask[$];
    logic [31:0]  waiter_ids[$];
    t_result_word awaited_results[$];

    int  words_sent;
    int  results_checked;
    int  firings_checked;
    int  mismatch_count;
    int  hold_request;   // set by a test, consumed by the receiver process
    bit  gaps_on;

    event_flag_waiter_matcher dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_set_mask   (i_set_mask),
        .i_clear_mask (i_clear_mask),
        .i_wait_mask  (i_wait_mask),
        .i_remove_id  (i_remove_id),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_fired      (o_fired),
        .o_waiter_id  (o_waiter_id),
        .o_flag_word  (o_flag_word),
        .o_last       (o_last)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS) begin
            $display("mismatch @%0t: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h, want %h", name, got, want));
        end
    endtask

    task automatic queue_result(input logic [1:0] status, input logic fired,
                                input logic [31:0] id, input logic last);
        t_result_word w;
        w.status    = status;
        w.fired     = fired;
        w.waiter_id = id;
        w.flag_word = group_flags;
        w.last      = last;
        awaited_results.push_back(w);
    endtask

    // Works out every result word caused by one accepted input word.
    task automatic advance_flag_group(input logic [1:0] kind, input logic [31:0] setm,
                                      input logic [31:0] clrm, input logic [31:0] waitm,
                                      input logic [31:0] rid);
        logic [31:0] prior_flags;
        int          hit;
        int          fires;
        int          i;
        case (kind)
            efwm_pkg::KIND_UPDATE: begin
                prior_flags = group_flags;
                group_flags = (group_flags | setm) & ~clrm;
                // Firing only starts when the word actually changed.
                if (group_flags != prior_flags) begin
                    fires = 0;
                    hit   = 0;
                    while (fires < efwm_pkg::FLAG_W && hit >= 0) begin
                        hit = -1;
                        for (i = 0; i < waiter_mask.size(); i++) begin
                            if (hit < 0 && (group_flags & waiter_mask[i]) == waiter_mask[i])
                                hit = i;
                        end
                        if (hit >= 0) begin
                            group_flags &= ~waiter_mask[hit];
                            queue_result(efwm_pkg::STATUS_OK, 1'b1, waiter_ids[hit], 1'b0);
                            fires++;
                        end
                    end
                end
                queue_result(efwm_pkg::STATUS_OK, 1'b0, '0, 1'b1);
            end
            efwm_pkg::KIND_ADD: begin
                if (waitm == '0) begin
                    queue_result(efwm_pkg::STATUS_ZERO_MASK, 1'b0, '0, 1'b1);
                end else if (waiter_mask.size() >= efwm_pkg::WAITER_SLOTS) begin
                    queue_result(efwm_pkg::STATUS_FULL, 1'b0, '0, 1'b1);
                end else begin
                    last_issued_id = last_issued_id + 32'd1;
                    waiter_mask.push_back(waitm);
                    waiter_ids.push_back(last_issued_id);
                    queue_result(efwm_pkg::STATUS_OK, 1'b0, last_issued_id, 1'b1);
                end
            end
            efwm_pkg::KIND_REMOVE: begin
                // Drop every waiter with that id; the rest keep their order.
                for (i = waiter_ids.size() - 1; i >= 0; i--) begin
                    if (waiter_ids[i] == rid) begin
                        waiter_ids.delete(i);
                        waiter_mask.delete(i);
                    end
                end
                queue_result(efwm_pkg::STATUS_OK, 1'b0, rid, 1'b1);
            end
            default: begin
                queue_result(efwm_pkg::STATUS_OK, 1'b0, '0, 1'b1);
            end
        endcase
    endtask

    // Offers one input word and returns at the falling edge after it was taken.
    // Entered and left at a falling edge; valid stays high when no gap is drawn.
    task automatic offer_word(input logic [1:0] kind, input logic [31:0] setm,
                              input logic [31:0] clrm, input logic [31:0] waitm,
                              input logic [31:0] rid);
        int gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_set_mask   <= setm;
        i_clear_mask <= clrm;
        i_wait_mask  <= waitm;
        i_remove_id  <= rid;
        do @(posedge i_clk); while (!o_in_ready);
        advance_flag_group(kind, setm, clrm, waitm, rid);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Sender pause: hold off until every result word is in, then let the block settle.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (awaited_results.size() != 0);
        repeat (DRAIN_TAIL) @(negedge i_clk);
    endtask

    // One to three set bits, anywhere in the word.
    function automatic logic [31:0] sparse_mask();
        logic [31:0] m;
        int          n;
        m = '0;
        n = $urandom_range(1, 3);
        repeat (n) m[5'($urandom_range(0, 31))] = 1'b1;
        return m;
    endfunction

    // One word of a well-formed waiter workload: adds of sparse masks, updates that
    // tend to satisfy live waiters, removes of live ids; unused fields are random.
    task automatic random_waiter_step();
        int          roll;
        logic [31:0] setm;
        logic [31:0] clrm;
        logic [31:0] rid;
        roll = $urandom_range(0, 99);
        // keep a full table from swallowing most of the adds
        if (roll < 30 && waiter_mask.size() == efwm_pkg::WAITER_SLOTS
            && $urandom_range(0, 2) != 0)
            roll = 70;
        if (roll < 30) begin
            offer_word(efwm_pkg::KIND_ADD, $urandom, $urandom, sparse_mask(), $urandom);
        end else if (roll < 65) begin
            setm = sparse_mask();
            if (waiter_mask.size() > 0 && $urandom_range(0, 2) != 0)
                setm |= waiter_mask[$urandom_range(0, waiter_mask.size() - 1)];
            clrm = ($urandom_range(0, 3) == 0) ? sparse_mask() : '0;
            offer_word(efwm_pkg::KIND_UPDATE, setm, clrm, $urandom, $urandom);
        end else if (roll < 90) begin
            if (waiter_ids.size() > 0 && $urandom_range(0, 3) != 0)
                rid = waiter_ids[$urandom_range(0, waiter_ids.size() - 1)];
            else
                rid = $urandom;
            offer_word(efwm_pkg::KIND_REMOVE, $urandom, $urandom, $urandom, rid);
        end else if (roll < 95) begin
            offer_word(efwm_pkg::KIND_ADD, $urandom, $urandom, '0, $urandom);
        end else begin
            offer_word(KIND_SPARE, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    // Each kind at least once, masks at the extremes, no-change update, zero mask, unknown id.
    task automatic test_directed_cases();
        offer_word(efwm_pkg::KIND_UPDATE, '0, '0, '0, '0);       // no change, summary only
        offer_word(efwm_pkg::KIND_ADD, '0, '0, '0, '0);          // zero mask rejected
        offer_word(efwm_pkg::KIND_ADD, '0, '0, 32'h0000_0001, '0);
        offer_word(efwm_pkg::KIND_ADD, '0, '0, 32'h8000_0000, '0);
        offer_word(efwm_pkg::KIND_ADD, '1, '1, 32'hFFFF_FFFF, '1);
        offer_word(efwm_pkg::KIND_UPDATE, 32'hFFFF_FFFF, '0, '0, '0); // two fire, all-ones loses
        offer_word(efwm_pkg::KIND_UPDATE, '0, 32'hFFFF_FFFF, '1, '1); // changed, nothing matches
        offer_word(efwm_pkg::KIND_REMOVE, '0, '0, '0, 32'hFFFF_FFFF); // unknown id
        offer_word(efwm_pkg::KIND_REMOVE, '0, '0, '0, 32'd2);
        offer_word(KIND_SPARE, '1, '1, '1, '1);
        offer_word(efwm_pkg::KIND_UPDATE, 32'h0000_00F0, 32'h0000_0030, '0, '0); // clear wins
        wait_for_results();
    endtask

    // Fill all slots with one-bit waiters, overflow, then fire every one of them.
    task automatic test_full_table();
        int b;
        offer_word(efwm_pkg::KIND_REMOVE, '0, '0, '0, 32'd3);
        for (b = 1; b < 16; b++) begin
            offer_word(efwm_pkg::KIND_ADD, '0, '0, 32'd1 << b, '0);
        end
        offer_word(efwm_pkg::KIND_ADD, '0, '0, 32'h0001_0000, '0);    // table full
        offer_word(efwm_pkg::KIND_UPDATE, 32'hFFFF_FFFF, '0, '0, '0); // sixteen firings
        offer_word(efwm_pkg::KIND_UPDATE, 32'h0001_0000, '0, '0, '0); // already set, no change
        wait_for_results();
    endtask

    // Receiver holds off long enough that the block fills and stops taking words.
    task automatic test_output_backpressure();
        hold_request = LONG_HOLD;
        repeat (12) random_waiter_step();
        wait_for_results();
    endtask

    task automatic test_random_sequences();
        repeat (70) random_waiter_step();
        gaps_on = 1'b0;                  // a back-to-back stretch on both sides
        repeat (30) random_waiter_step();
        gaps_on = 1'b1;
        repeat (20) random_waiter_step();
        wait_for_results();
    endtask

    // Unshaped words: any kind, all fields fully random.
    task automatic test_random_noise();
        repeat (25) begin
            offer_word(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
        end
        wait_for_results();
    endtask

    // Result checker: every accepted output word against the oldest expectation.
    always @(posedge i_clk) begin
        t_result_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = awaited_results.pop_front();
                check_field("status", 32'(o_status), 32'(want.status));
                check_field("fired", 32'(o_fired), 32'(want.fired));
                check_field("waiter_id", o_waiter_id, want.waiter_id);
                check_field("flag_word", o_flag_word, want.flag_word);
                check_field("last", 32'(o_last), 32'(want.last));
                results_checked++;
                if (want.fired)
                    firings_checked++;
            end
        end
    end

    // Output side: random ready gaps per word, or a long hold when a test asks.
    initial begin
        int gap;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_request > 0) begin
                gap = hold_request;
                hold_request = 0;
            end else begin
                gap = gaps_on ? $urandom_range(0, 3) : 0;
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid && hold_request == 0);
            @(negedge i_clk);
        end
    end

    // Watchdog: ends the run if no word moves on either side for too long.
    initial begin
        int quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_kind          = efwm_pkg::KIND_UPDATE;
        i_set_mask      = '0;
        i_clear_mask    = '0;
        i_wait_mask     = '0;
        i_remove_id     = '0;
        group_flags     = '0;
        last_issued_id  = '0;
        words_sent      = 0;
        results_checked = 0;
        firings_checked = 0;
        mismatch_count  = 0;
        hold_request    = 0;
        gaps_on         = 1'b1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_full_table();
        test_output_backpressure();
        test_random_sequences();
        test_random_noise();

        if (awaited_results.size() != 0) begin
            report_mismatch($sformatf("%0d result words never arrived",
                                      awaited_results.size()));
        end
        $display("run covered %0d input words of every kind, zero masks, a full table",
                 words_sent);
        $display("and a long output stall; %0d result words checked, %0d firings, %0d bad",
                 results_checked, firings_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
